// ----- rtl/core/wlcf_pkg.sv -----
// ----------------------------------------------------------------------------
// wlcf_pkg
// Shared types and constants of the Wallis local-contrast filter core.
// ----------------------------------------------------------------------------
package wlcf_pkg;

  localparam int unsigned PSUM_W    = 19;
  localparam int unsigned SSUM_W    = 27;
  localparam int unsigned DVD_W     = 27;
  localparam int unsigned DVS_W     = 15;
  localparam int unsigned DIV_STEPS = 27;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MEAN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_VARIANCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTRAST_Q4     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS_Q4   = 2'd3;

  localparam logic [7:0]  RST_TARGET_MEAN     = 8'd127;
  localparam logic [13:0] RST_TARGET_VARIANCE = 14'd3600;
  localparam logic [4:0]  RST_CONTRAST_Q4     = 5'd13;
  localparam logic [4:0]  RST_BRIGHTNESS_Q4   = 5'd8;

  typedef struct packed {
    logic [7:0]  target_mean;
    logic [13:0] target_variance;
    logic [4:0]  contrast_q4;
    logic [4:0]  brightness_q4;
  } cfg_t;

  typedef struct packed {
    logic [7:0]        centre;
    logic [PSUM_W-1:0] psum;
    logic [SSUM_W-1:0] ssum;
    logic              last;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_UPD,
    F_CRD,
    F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_DMEAN,
    B_DSQ,
    B_CALC1,
    B_CALC2,
    B_DREC,
    B_MUL,
    B_FIN,
    B_OUT
  } back_state_t;

endpackage

// ----- rtl/core/wlcf_ram.sv -----
// ----------------------------------------------------------------------------
// wlcf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wlcf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 441
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/wlcf_fifo.sv -----
// ----------------------------------------------------------------------------
// wlcf_fifo
// Two-entry job queue between the window front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module wlcf_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  wlcf_pkg::job_t  push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output wlcf_pkg::job_t  pop_data
);

  wlcf_pkg::job_t slot_r [2];
  logic           wptr_r, wptr_nxt;
  logic           rptr_r, rptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = slot_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wptr_nxt = do_push ? ~wptr_r : wptr_r;
    rptr_nxt = do_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/core/wlcf_front.sv -----
// ----------------------------------------------------------------------------
// wlcf_front
// Window store, running sums, column bookkeeping; a job per column once full.
// ----------------------------------------------------------------------------
module wlcf_front #(
  parameter int unsigned WIN = 21
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_pixel,
  input  logic           in_column_end,
  input  logic           in_stream_last,
  output logic           job_valid,
  input  logic           job_ready,
  output wlcf_pkg::job_t job_data
);

  localparam int unsigned DEPTH  = WIN * WIN;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned IW     = $clog2(WIN);
  localparam int unsigned CW     = $clog2(WIN + 1);
  localparam int unsigned SW     = CW + 1;
  localparam int unsigned CENTRE = WIN / 2;

  wlcf_pkg::front_state_t state_r, state_nxt;

  logic [7:0]                  pix_r;
  logic                        cend_r, last_r;
  logic [AW-1:0]               idx_r, idx_nxt;
  logic [IW-1:0]               row_r, row_nxt;
  logic [IW-1:0]               oldest_r, oldest_nxt;
  logic [CW-1:0]               loaded_r, loaded_nxt;
  logic [wlcf_pkg::PSUM_W-1:0] psum_r, psum_nxt;
  logic [wlcf_pkg::SSUM_W-1:0] ssum_r, ssum_nxt;

  logic          full, col_done, in_xfer;
  logic [SW-1:0] slot_sum, cslot_sum;
  logic [IW-1:0] slot, cslot;
  logic [AW-1:0] cent_addr, raddr;
  logic [7:0]    rdata, old_pix;
  logic [15:0]   old_sq, new_sq;
  logic          ram_we;

  assign in_xfer  = in_tvalid && in_tready;
  assign in_tready = (state_r == wlcf_pkg::F_IDLE);
  assign full     = (loaded_r >= CW'(WIN));
  assign col_done = cend_r || (row_r == IW'(WIN - 1));

  always_comb begin
    slot_sum  = SW'(oldest_r) + SW'(loaded_r);
    slot      = (slot_sum >= SW'(WIN)) ? IW'(slot_sum - SW'(WIN)) : IW'(slot_sum);
    if (full) begin
      slot = oldest_r;
    end
    idx_nxt   = AW'(slot) * AW'(WIN) + AW'(row_r);
    cslot_sum = SW'(oldest_r) + SW'(CENTRE);
    cslot     = (cslot_sum >= SW'(WIN)) ? IW'(cslot_sum - SW'(WIN)) : IW'(cslot_sum);
    cent_addr = AW'(cslot) * AW'(WIN) + AW'(CENTRE);
    raddr     = (state_r == wlcf_pkg::F_IDLE) ? idx_nxt : cent_addr;
  end

  assign ram_we = (state_r == wlcf_pkg::F_UPD);

  wlcf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (pix_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign old_pix = full ? rdata : 8'd0;
  assign old_sq  = old_pix * old_pix;
  assign new_sq  = pix_r * pix_r;

  assign job_valid       = (state_r == wlcf_pkg::F_PUSH);
  assign job_data.centre = rdata;
  assign job_data.psum   = psum_r;
  assign job_data.ssum   = ssum_r;
  assign job_data.last   = last_r;

  always_comb begin
    state_nxt  = state_r;
    row_nxt    = row_r;
    oldest_nxt = oldest_r;
    loaded_nxt = loaded_r;
    psum_nxt   = psum_r;
    ssum_nxt   = ssum_r;
    case (state_r)
      wlcf_pkg::F_IDLE: begin
        if (in_xfer) begin
          state_nxt = wlcf_pkg::F_UPD;
        end
      end
      wlcf_pkg::F_UPD: begin
        psum_nxt = psum_r - wlcf_pkg::PSUM_W'(old_pix) + wlcf_pkg::PSUM_W'(pix_r);
        ssum_nxt = ssum_r - wlcf_pkg::SSUM_W'(old_sq) + wlcf_pkg::SSUM_W'(new_sq);
        if (!col_done) begin
          row_nxt   = row_r + IW'(1);
          state_nxt = wlcf_pkg::F_IDLE;
        end else begin
          row_nxt = '0;
          if (full) begin
            oldest_nxt = (oldest_r == IW'(WIN - 1)) ? '0 : oldest_r + IW'(1);
            state_nxt  = wlcf_pkg::F_CRD;
          end else begin
            loaded_nxt = loaded_r + CW'(1);
            state_nxt  = (loaded_nxt == CW'(WIN)) ? wlcf_pkg::F_CRD : wlcf_pkg::F_IDLE;
            if ((loaded_nxt != CW'(WIN)) && last_r) begin
              oldest_nxt = '0;
              loaded_nxt = '0;
              psum_nxt   = '0;
              ssum_nxt   = '0;
            end
          end
        end
      end
      wlcf_pkg::F_CRD: begin
        state_nxt = wlcf_pkg::F_PUSH;
      end
      wlcf_pkg::F_PUSH: begin
        if (job_ready) begin
          state_nxt = wlcf_pkg::F_IDLE;
          if (last_r) begin
            oldest_nxt = '0;
            loaded_nxt = '0;
            psum_nxt   = '0;
            ssum_nxt   = '0;
          end
        end
      end
      default: begin
        state_nxt = wlcf_pkg::F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= wlcf_pkg::F_IDLE;
      row_r    <= '0;
      oldest_r <= '0;
      loaded_r <= '0;
      psum_r   <= '0;
      ssum_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      row_r    <= row_nxt;
      oldest_r <= oldest_nxt;
      loaded_r <= loaded_nxt;
      psum_r   <= psum_nxt;
      ssum_r   <= ssum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pix_r  <= in_pixel;
      cend_r <= in_column_end;
      last_r <= in_stream_last;
      idx_r  <= idx_nxt;
    end
  end

endmodule

// ----- rtl/core/wlcf_back.sv -----
// ----------------------------------------------------------------------------
// wlcf_back
// Window statistics by reciprocal multiplication and the Wallis formula,
// with a bit-serial divider for the denominator reciprocal.
// ----------------------------------------------------------------------------
module wlcf_back #(
  parameter int unsigned WIN = 21
) (
  input  logic           clk,
  input  logic           rst_n,
  input  wlcf_pkg::cfg_t cfg,
  input  logic           job_valid,
  output logic           job_ready,
  input  wlcf_pkg::job_t job_data,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_pixel,
  output logic           out_last
);

  localparam int unsigned NPIX   = WIN * WIN;
  localparam int unsigned CNTW   = $clog2(wlcf_pkg::DIV_STEPS);
  localparam int unsigned NSH    = wlcf_pkg::DVD_W + $clog2(NPIX);
  localparam int unsigned RCPW   = wlcf_pkg::DVD_W + 1;
  // ceil(2^NSH / NPIX): exact floor division for every 27-bit sum
  localparam logic [63:0] NRECIP = ((64'd1 << NSH) + 64'(NPIX) - 64'd1) / 64'(NPIX);

  wlcf_pkg::back_state_t state_r, state_nxt;
  wlcf_pkg::job_t        job_r;

  logic [wlcf_pkg::DVD_W-1:0] dvd_r, dvd_nxt;
  logic [wlcf_pkg::DVS_W-1:0] dvs_r, dvs_nxt;
  logic [wlcf_pkg::DVS_W-1:0] rem_r, rem_nxt;
  logic [wlcf_pkg::DVD_W-1:0] quo_r, quo_nxt;
  logic [CNTW-1:0]            cnt_r, cnt_nxt;
  logic [wlcf_pkg::DVS_W:0]   rem_sh;
  logic                       q_bit, div_last;

  logic [wlcf_pkg::DVD_W-1:0]      nd_opd;
  logic [wlcf_pkg::DVD_W+RCPW-1:0] nd_prod;

  logic [7:0]  mean_r, mean_nxt;
  logic [13:0] sq_r, sq_nxt;
  logic [13:0] msq_r, msq_nxt;
  logic [22:0] t_r, t_nxt;
  logic [7:0]  bg_r, bg_nxt;
  logic [13:0] cg_r, cg_nxt;
  logic [7:0]  bm_r, bm_nxt;
  logic [22:0] num_r, num_nxt;
  logic [14:0] d_r, d_nxt;
  logic [17:0] r_r, r_nxt;
  logic [22:0] q_r, q_nxt;
  logic [7:0]  res_r, res_nxt;
  logic        ov_r, ov_nxt;
  logic [7:0]  opix_r, opix_nxt;
  logic        olast_r, olast_nxt;

  logic signed [8:0]  dpm;
  logic signed [23:0] t_full;
  logic signed [5:0]  omc, omb;
  logic signed [20:0] cg_full;
  logic signed [14:0] bm_full;
  logic [12:0]        bg_full;
  logic [13:0]        var_w;
  logic [18:0]        cv_full;
  logic signed [28:0] tc_full;
  logic signed [41:0] prod;
  logic signed [23:0] wsum;
  logic [22:0]        w23;

  assign rem_sh   = {rem_r, dvd_r[wlcf_pkg::DVD_W-1]};
  assign q_bit    = (rem_sh >= {1'b0, dvs_r});
  assign div_last = (cnt_r == CNTW'(wlcf_pkg::DIV_STEPS - 1));

  assign job_ready  = (state_r == wlcf_pkg::B_IDLE);
  assign out_tvalid = ov_r;
  assign out_pixel  = opix_r;
  assign out_last   = olast_r;

  always_comb begin
    nd_opd  = (state_r == wlcf_pkg::B_DMEAN) ? wlcf_pkg::DVD_W'(job_r.psum) : job_r.ssum;
    nd_prod = nd_opd * NRECIP[RCPW-1:0];
    dpm     = $signed({1'b0, job_r.centre}) - $signed({1'b0, mean_r});
    t_full  = dpm * $signed({1'b0, cfg.target_variance});
    omc     = 6'sd16 - $signed({1'b0, cfg.contrast_q4});
    omb     = 6'sd16 - $signed({1'b0, cfg.brightness_q4});
    cg_full = omc * $signed({1'b0, cfg.target_variance});
    bm_full = omb * $signed({1'b0, mean_r});
    bg_full = cfg.brightness_q4 * cfg.target_mean;
    var_w   = sq_r - msq_r;
    cv_full = cfg.contrast_q4 * var_w;
    tc_full = $signed(t_r) * $signed({1'b0, cfg.contrast_q4});
    prod    = $signed(num_r) * $signed({1'b0, r_r});
    wsum    = $signed({q_r[22], q_r}) + $signed({16'd0, bg_r}) + $signed({16'd0, bm_r});
    w23     = wsum[22:0];
  end

  always_comb begin
    state_nxt = state_r;
    dvd_nxt   = {dvd_r[wlcf_pkg::DVD_W-2:0], 1'b0};
    dvs_nxt   = dvs_r;
    rem_nxt   = q_bit ? wlcf_pkg::DVS_W'(rem_sh - {1'b0, dvs_r})
                      : wlcf_pkg::DVS_W'(rem_sh);
    quo_nxt   = {quo_r[wlcf_pkg::DVD_W-2:0], q_bit};
    cnt_nxt   = cnt_r + CNTW'(1);
    mean_nxt  = mean_r;
    sq_nxt    = sq_r;
    msq_nxt   = msq_r;
    t_nxt     = t_r;
    bg_nxt    = bg_r;
    cg_nxt    = cg_r;
    bm_nxt    = bm_r;
    num_nxt   = num_r;
    d_nxt     = d_r;
    r_nxt     = r_r;
    q_nxt     = q_r;
    res_nxt   = res_r;
    ov_nxt    = ov_r && !out_tready;
    opix_nxt  = opix_r;
    olast_nxt = olast_r;
    case (state_r)
      wlcf_pkg::B_IDLE: begin
        if (job_valid) begin
          state_nxt = wlcf_pkg::B_DMEAN;
        end
      end
      wlcf_pkg::B_DMEAN: begin
        mean_nxt  = nd_prod[NSH +: 8];
        state_nxt = wlcf_pkg::B_DSQ;
      end
      wlcf_pkg::B_DSQ: begin
        sq_nxt    = nd_prod[NSH +: 14];
        state_nxt = wlcf_pkg::B_CALC1;
      end
      wlcf_pkg::B_CALC1: begin
        msq_nxt   = 14'(mean_r * mean_r);
        t_nxt     = t_full[22:0];
        bg_nxt    = bg_full[11:4];
        cg_nxt    = cg_full[17:4];
        bm_nxt    = bm_full[11:4];
        state_nxt = wlcf_pkg::B_CALC2;
      end
      wlcf_pkg::B_CALC2: begin
        num_nxt   = tc_full[26:4];
        d_nxt     = {1'b0, cv_full[17:4]} + {1'b0, cg_r};
        dvd_nxt   = wlcf_pkg::DVD_W'(1) << 17;
        dvs_nxt   = d_nxt;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = wlcf_pkg::B_DREC;
      end
      wlcf_pkg::B_DREC: begin
        if (div_last) begin
          r_nxt     = (d_r == '0) ? '1 : quo_nxt[17:0];
          state_nxt = wlcf_pkg::B_MUL;
        end
      end
      wlcf_pkg::B_MUL: begin
        q_nxt     = prod[39:17];
        state_nxt = wlcf_pkg::B_FIN;
      end
      wlcf_pkg::B_FIN: begin
        if (w23[22]) begin
          res_nxt = 8'd0;
        end else if (w23[21:8] != '0) begin
          res_nxt = 8'hFF;
        end else begin
          res_nxt = w23[7:0];
        end
        state_nxt = wlcf_pkg::B_OUT;
      end
      wlcf_pkg::B_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          opix_nxt  = res_r;
          olast_nxt = job_r.last;
          state_nxt = wlcf_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = wlcf_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wlcf_pkg::B_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      job_r <= job_data;
    end
    dvd_r   <= dvd_nxt;
    dvs_r   <= dvs_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    cnt_r   <= cnt_nxt;
    mean_r  <= mean_nxt;
    sq_r    <= sq_nxt;
    msq_r   <= msq_nxt;
    t_r     <= t_nxt;
    bg_r    <= bg_nxt;
    cg_r    <= cg_nxt;
    bm_r    <= bm_nxt;
    num_r   <= num_nxt;
    d_r     <= d_nxt;
    r_r     <= r_nxt;
    q_r     <= q_nxt;
    res_r   <= res_nxt;
    opix_r  <= opix_nxt;
    olast_r <= olast_nxt;
  end

endmodule

// ----- rtl/core/wallis_local_contrast_filter_core.sv -----
// ----------------------------------------------------------------------------
// wallis_local_contrast_filter_core
// Wallis local-contrast filter over a sliding WINDOW_LENGTH square window.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in_     | slave     | tdata: pixel[7:0]; tuser: column_end; tlast: stream_last
//  out_    | master    | tdata: out_pixel[7:0]; tlast: out_last
//  cfg_    | write     | index 0..3, data up to 14 bits
//
//  In the front end a pixel is read from the store, then updated and written;
//  a column end that yields a result adds a centre read and a push.
//  The back end forms each result from mean and mean square by
//  reciprocal multiplication, then a 27-step divider pass for the Wallis
//  reciprocal. A two-entry queue decouples the halves; a held output stalls
//  the back end in its last step. Reset is synchronous; the store needs no clearing.
// ----------------------------------------------------------------------------
module wallis_local_contrast_filter_core #(
  parameter int unsigned WINDOW_LENGTH = 21
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [7:0] pixel
  input  logic                               in_tuser,   // [0] column_end
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [7:0]                         out_tdata,  // [7:0] out_pixel
  output logic                               out_tlast,
  input  logic                               cfg_wr_en,
  input  logic [wlcf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wlcf_pkg::CFG_DAT_W-1:0]     cfg_wdata
);

  wlcf_pkg::cfg_t cfg_r;
  wlcf_pkg::job_t fq_in, fq_out;
  logic           fq_in_valid, fq_in_ready, fq_out_valid, fq_out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_mean     <= wlcf_pkg::RST_TARGET_MEAN;
      cfg_r.target_variance <= wlcf_pkg::RST_TARGET_VARIANCE;
      cfg_r.contrast_q4     <= wlcf_pkg::RST_CONTRAST_Q4;
      cfg_r.brightness_q4   <= wlcf_pkg::RST_BRIGHTNESS_Q4;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        wlcf_pkg::CFG_TARGET_MEAN:     cfg_r.target_mean     <= cfg_wdata[7:0];
        wlcf_pkg::CFG_TARGET_VARIANCE: cfg_r.target_variance <= cfg_wdata[13:0];
        wlcf_pkg::CFG_CONTRAST_Q4:     cfg_r.contrast_q4     <= cfg_wdata[4:0];
        wlcf_pkg::CFG_BRIGHTNESS_Q4:   cfg_r.brightness_q4   <= cfg_wdata[4:0];
        default: begin
        end
      endcase
    end
  end

  wlcf_front #(
    .WIN (WINDOW_LENGTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_pixel       (in_tdata),
    .in_column_end  (in_tuser),
    .in_stream_last (in_tlast),
    .job_valid      (fq_in_valid),
    .job_ready      (fq_in_ready),
    .job_data       (fq_in)
  );

  wlcf_fifo u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_in_valid),
    .push_ready (fq_in_ready),
    .push_data  (fq_in),
    .pop_valid  (fq_out_valid),
    .pop_ready  (fq_out_ready),
    .pop_data   (fq_out)
  );

  wlcf_back #(
    .WIN (WINDOW_LENGTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .job_valid  (fq_out_valid),
    .job_ready  (fq_out_ready),
    .job_data   (fq_out),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_pixel  (out_tdata),
    .out_last   (out_tlast)
  );

`ifndef SYNTHESIS
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("front end took a second pixel while busy");

  a_out_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (fq_in_valid && !fq_in_ready) |=> fq_in_valid && $stable(fq_in))
    else $error("job dropped or changed while queue full");
`endif

endmodule
